### sv/tab_pkg.sv
package tab_pkg;

  localparam int COUNT_BITS = 24;
  localparam int SUM_W = 40;
  localparam int ACC_W = 16;
  localparam int TIME_W = 32;
  localparam int IVL_W = 16;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(1000);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BUSY,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Controls from the sequencer to the accumulator.
  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctl_t;

endpackage

### sv/tab_if.sv
interface tab_in_if import tab_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_z;
  logic packet_end;
  logic [TIME_W-1:0] packet_time;

  modport source (output valid, acc_x, acc_y, acc_z, packet_end, packet_time,
                  input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, packet_end, packet_time,
                output ready);
endinterface

interface tab_out_if import tab_pkg::*; ();
  logic valid;
  logic ready;
  logic [TIME_W-1:0] publish_time;
  logic signed [ACC_W-1:0] avg_x;
  logic signed [ACC_W-1:0] avg_y;
  logic signed [ACC_W-1:0] avg_z;

  modport source (output valid, publish_time, avg_x, avg_y, avg_z, input ready);
  modport sink (input valid, publish_time, avg_x, avg_y, avg_z, output ready);
endinterface

interface tab_cfg_if import tab_pkg::*; ();
  logic valid;
  logic ready;
  logic [IVL_W-1:0] min_gap_ms;

  modport source (output valid, min_gap_ms, input ready);
  modport sink (input valid, min_gap_ms, output ready);
endinterface

### sv/tab_div.sv
module tab_div import tab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dvs_r, dvs_nxt;
  logic                  done_r, done_nxt;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quo_r while quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff = trial - {1'b0, dvs_r};
    step_nxt = step_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      step_nxt = STEP_W'(DIV_STEPS);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (step_r != '0) begin
      step_nxt = step_r - STEP_W'(1);
      done_nxt = (step_r == STEP_W'(1));
      if (!diff[COUNT_BITS]) begin
        rem_nxt = diff[COUNT_BITS-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_BITS-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> step_r == STEP_W'(DIV_STEPS))
    else $error("divider did not load its step count");
  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> step_r == '0)
    else $error("divider done while steps remain");
  a_step_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0 && !start) |=> step_r == $past(step_r) - STEP_W'(1))
    else $error("divider step count skipped");
`endif

endmodule

### sv/tab_accum.sv
module tab_accum import tab_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acc_ctl_t                 ctl,
  input  logic signed [ACC_W-1:0]  acc_x,
  input  logic signed [ACC_W-1:0]  acc_y,
  input  logic signed [ACC_W-1:0]  acc_z,
  input  logic [TIME_W-1:0]        packet_time,
  input  logic [TIME_W-1:0]        commit_time,
  input  logic [IVL_W-1:0]         interval,
  output logic signed [SUM_W-1:0]  sum_x,
  output logic signed [SUM_W-1:0]  sum_y,
  output logic signed [SUM_W-1:0]  sum_z,
  output logic [COUNT_BITS-1:0]    count,
  output logic                     time_ok
);

  logic signed [SUM_W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [TIME_W-1:0]        last_r, last_nxt;
  logic [TIME_W-1:0]        limit;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [ACC_W-1:0] a);
    logic [SUM_W:0] r;
    r = {s[SUM_W-1], s} + {{(SUM_W + 1 - ACC_W){a[ACC_W-1]}}, a};
    if (r[SUM_W] != r[SUM_W-1]) begin
      sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = r[SUM_W-1:0];
    end
  endfunction

  // Publish when the timestamp passes the wrapped deadline or the time base wrapped.
  assign limit = last_r + TIME_W'(interval);
  assign time_ok = (packet_time > limit) || (packet_time < last_r);

  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    sz_nxt = sz_r;
    cnt_nxt = cnt_r;
    last_nxt = last_r;
    if (ctl.clear) begin
      sx_nxt = '0;
      sy_nxt = '0;
      sz_nxt = '0;
      cnt_nxt = '0;
      last_nxt = commit_time;
    end else if (ctl.add && cnt_r != '1) begin
      sx_nxt = sat_add(sx_r, acc_x);
      sy_nxt = sat_add(sy_r, acc_y);
      sz_nxt = sat_add(sz_r, acc_z);
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      sz_r <= '0;
      cnt_r <= '0;
      last_r <= '0;
    end else begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      sz_r <= sz_nxt;
      cnt_r <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  assign sum_x = sx_r;
  assign sum_y = sy_r;
  assign sum_z = sz_r;
  assign count = cnt_r;

endmodule

### sv/timed_three_axis_block_averager_core.sv
// A non-publishing sample is accepted in idle; the next may follow at once.
// A publishing sample runs one shared 40-step restoring divider once per axis, and
// no samples are taken meanwhile; an empty block skips the divider.
// The result sits in an output register, so new samples are taken while it waits.
// Synchronous active-low reset clears the sums, count, last publish time and the
// output valid, and sets the publish interval to 1000 ms.
module timed_three_axis_block_averager_core import tab_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tab_in_if.sink     in_ch,
  tab_out_if.source  out_ch,
  tab_cfg_if.sink    cfg_ch
);

  seq_state_t state_r, state_nxt;
  axis_t      axis_r, axis_nxt;

  logic [IVL_W-1:0]        interval_r;
  logic [TIME_W-1:0]       time_r, time_nxt;
  logic                    neg_r, neg_nxt;
  logic [ACC_W-1:0]        avg_x_r, avg_x_nxt, avg_y_r, avg_y_nxt, avg_z_r, avg_z_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]       out_time_r;
  logic [ACC_W-1:0]        out_x_r, out_y_r, out_z_r;

  logic                    in_fire;
  logic                    emit_go;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [SUM_W-1:0]        sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic [COUNT_BITS-1:0]   count;
  logic                    time_ok;
  logic [ACC_W-1:0]        q_lo;
  logic [ACC_W-1:0]        mean;
  acc_ctl_t                acc_ctl;

  // Requests are taken only while the sequencer waits for samples.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // The output slot frees when its result is taken in this same cycle.
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  tab_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (acc_ctl),
    .acc_x       (in_ch.acc_x),
    .acc_y       (in_ch.acc_y),
    .acc_z       (in_ch.acc_z),
    .packet_time (in_ch.packet_time),
    .commit_time (time_r),
    .interval    (interval_r),
    .sum_x       (sum_x),
    .sum_y       (sum_y),
    .sum_z       (sum_z),
    .count       (count),
    .time_ok     (time_ok)
  );

  // The axis being divided picks its sum; the divider works on the magnitude
  // and the sign is put back on the truncated quotient.
  always_comb begin
    unique case (axis_r)
      AXIS_X:  sum_sel = sum_x;
      AXIS_Y:  sum_sel = sum_y;
      AXIS_Z:  sum_sel = sum_z;
      default: sum_sel = sum_x;
    endcase
  end

  assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;
  assign div_start = (state_r == ST_START) && (count != '0);

  tab_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_lo = div_quo[ACC_W-1:0];
  assign mean = neg_r ? (~q_lo + ACC_W'(1)) : q_lo;

  // Sequencer: accumulate in idle, then per axis start the divider and collect its
  // quotient (an empty block skips the divider), then hand the result to the output register.
  always_comb begin
    state_nxt = state_r;
    axis_nxt = axis_r;
    time_nxt = time_r;
    neg_nxt = neg_r;
    avg_x_nxt = avg_x_r;
    avg_y_nxt = avg_y_r;
    avg_z_nxt = avg_z_r;
    acc_ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_ctl.add = 1'b1;
          if (in_ch.packet_end && time_ok) begin
            time_nxt = in_ch.packet_time;
            axis_nxt = AXIS_X;
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        if (count == '0) begin
          // An empty block averages to zero on every axis.
          avg_x_nxt = '0;
          avg_y_nxt = '0;
          avg_z_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          neg_nxt = sum_sel[SUM_W-1];
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (div_done) begin
          unique case (axis_r)
            AXIS_X: begin
              avg_x_nxt = mean;
              axis_nxt = AXIS_Y;
              state_nxt = ST_START;
            end
            AXIS_Y: begin
              avg_y_nxt = mean;
              axis_nxt = AXIS_Z;
              state_nxt = ST_START;
            end
            default: begin
              avg_z_nxt = mean;
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          acc_ctl.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r <= AXIS_X;
      out_valid_r <= 1'b0;
      interval_r <= INTERVAL_RESET;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        interval_r <= cfg_ch.min_gap_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    neg_r <= neg_nxt;
    avg_x_r <= avg_x_nxt;
    avg_y_r <= avg_y_nxt;
    avg_z_r <= avg_z_nxt;
    if (emit_go) begin
      out_time_r <= time_r;
      out_x_r <= avg_x_r;
      out_y_r <= avg_y_r;
      out_z_r <= avg_z_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.publish_time = out_time_r;
  assign out_ch.avg_x = out_x_r;
  assign out_ch.avg_y = out_y_r;
  assign out_ch.avg_z = out_z_r;

`ifndef NO_ASSERTIONS
  a_publish_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.packet_end && time_ok) |=> state_r == ST_START)
    else $error("publishing request did not start the divider sequence");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && count == '0))
    else $error("result loaded without clearing the accumulator");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("output became valid outside the emit step");
`endif

endmodule
